// File: hw/rtl/spsc_pkg.sv
`timescale 1ns / 1ps
package spsc_pkg;

    // Encoder geometry
    localparam int ANGLE_W   = 14;
    localparam int TURN_W    = 16;
    localparam int SPEED_W   = 24;
    localparam int DUR_W     = 24;
    localparam int CFG_W     = 23;
    localparam int HALF_TURN = 1 << (ANGLE_W - 1);
    localparam int POS_W     = TURN_W + ANGLE_W;

    // Timed speed: dist * 3072000 / (16384 * ticks) = dist * 375 / (2 * ticks)
    localparam int TIMED_NUM = 375;
    localparam int NUM_W     = 22;
    localparam int DIV_W     = DUR_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = 5;

    // Action codes
    localparam logic [2:0] ACT_SAMPLE = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_SPEED  = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_GOTO   = 3'd4;
    localparam logic [2:0] ACT_NEAR   = 3'd5;
    localparam logic [2:0] ACT_TIMED  = 3'd6;

    // Mode codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SPEED = 2'd1;
    localparam logic [1:0] MODE_GOTO  = 2'd2;
    localparam logic [1:0] MODE_TIMED = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_KP      = 3'd0;
    localparam logic [2:0] CFG_STOP    = 3'd1;
    localparam logic [2:0] CFG_BACK    = 3'd2;
    localparam logic [2:0] CFG_MIN     = 3'd3;
    localparam logic [2:0] CFG_STEP    = 3'd4;
    localparam logic [2:0] CFG_SETTLE  = 3'd5;
    localparam logic [2:0] CFG_DEFMAX  = 3'd6;

    typedef struct packed {
        logic [2:0]                action;
        logic [ANGLE_W-1:0]        angle;
        logic signed [TURN_W-1:0]  turn_number;
        logic signed [SPEED_W-1:0] speed_value;
        logic [DUR_W-1:0]          duration_ticks;
    } t_in_req;

    typedef struct packed {
        logic                      drive_update;
        logic signed [SPEED_W-1:0] drive_speed;
        logic [1:0]                mode_now;
        logic                      goto_done;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic div_start;
        logic div_step;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic is_timed;
        logic div_last;
    } t_dp_status;

endpackage

// File: hw/rtl/stepper_position_speed_controller.sv
`timescale 1ns / 1ps
// Stepper position and speed controller.
// Input channel (i_in_valid / o_in_ready / i_in): one request per encoder
// sample, 5 ms control tick or motion command. Output channel (o_out_valid /
// i_out_ready / o_out): exactly one result per request, in order.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at once;
// write only while no request is in flight.
// Each request passes through the states prep, multiply and commit; a timed
// move also runs a restoring divider (one quotient bit per cycle) between
// multiply and commit. One request is in flight at a time: a new request is
// taken only back in idle, after the last one has committed.
// A finished result sits in the output register; the next request is taken
// and worked on meanwhile, and waits before commit while the receiver stalls.
// Reset (synchronous, active low) loads the default gains and bands, clears
// position tracking and all motion state, and leaves the mode idle.
module stepper_position_speed_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  spsc_pkg::t_in_req          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output spsc_pkg::t_out_req         o_out,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [spsc_pkg::CFG_W-1:0] i_cfg_data
);
    import spsc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    spsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    spsc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out      (o_out)
    );

endmodule

// File: hw/rtl/spsc_ctrl.sv
`timescale 1ns / 1ps
module spsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  spsc_pkg::t_dp_status i_status,
    output spsc_pkg::t_dp_cmd    o_cmd
);
    import spsc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence one request through prep, multiply, divide (timed moves only) and commit
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul       = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = i_status.is_timed ? S_DIV : S_APPLY;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_slot_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/spsc_datapath.sv
`timescale 1ns / 1ps
module spsc_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spsc_pkg::t_in_req       i_in,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [spsc_pkg::CFG_W-1:0] i_cfg_data,
    input  spsc_pkg::t_dp_cmd       i_cmd,
    output spsc_pkg::t_dp_status    o_status,
    output spsc_pkg::t_out_req      o_out
);
    import spsc_pkg::*;

    // Configuration
    logic [15:0]      r_kp;
    logic [13:0]      r_stop_band;
    logic [13:0]      r_back_band;
    logic [CFG_W-1:0] r_min;
    logic [CFG_W-1:0] r_step;
    logic [15:0]      r_settle_ticks;
    logic [CFG_W-1:0] r_defmax;

    // Controller state
    logic [1:0]                r_mode, n_mode;
    logic [TURN_W-1:0]         r_turn, n_turn;
    logic [ANGLE_W-1:0]        r_prev, n_prev;
    logic                      r_track, n_track;
    logic [31:0]               r_target, n_target;
    logic [SPEED_W-1:0]        r_limit, n_limit;
    logic signed [SPEED_W-1:0] r_gsn, n_gsn;
    logic [15:0]               r_settle, n_settle;
    logic [DUR_W-1:0]          r_left, n_left;
    logic signed [SPEED_W-1:0] r_spd_tgt, n_spd_tgt;

    // Work registers
    t_in_req              r_in;
    logic [31:0]          r_mag;
    logic                 r_err_pos;
    logic signed [14:0]   r_off;
    logic [47:0]          r_prod;
    logic [NUM_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_out_req             r_out, n_out;

    // Prep: position error, nearest-angle offset and timed-speed numerator
    logic signed [33:0] w_err, w_err_abs;
    logic [ANGLE_W-1:0] w_r;
    logic signed [30:0] w_d;
    logic               w_tie_pos;
    logic signed [14:0] w_off;
    logic [13:0]        w_off_abs;
    logic [22:0]        w_num_full;

    assign w_err = {{2{r_target[31]}}, r_target}
                 - {{4{r_turn[TURN_W-1]}}, r_turn, r_in.angle};
    assign w_err_abs = w_err[33] ? -w_err : w_err;
    assign w_r = r_in.angle - r_prev;
    assign w_d = {17'b0, r_in.angle} - {r_turn[TURN_W-1], r_turn, r_prev};
    assign w_tie_pos = !w_d[30] && (w_d[29:0] >= 30'(HALF_TURN));

    always_comb begin
        if (w_r < ANGLE_W'(HALF_TURN)) begin
            w_off = {1'b0, w_r};
        end else if (w_r > ANGLE_W'(HALF_TURN)) begin
            w_off = {1'b0, w_r} - 15'(2 * HALF_TURN);
        end else if (w_tie_pos) begin
            w_off = 15'(HALF_TURN);
        end else begin
            w_off = -15'(HALF_TURN);
        end
    end

    assign w_off_abs  = w_off[14] ? 14'(-w_off) : 14'(w_off);
    assign w_num_full = w_off_abs * 9'(TIMED_NUM);

    // Divider step: restoring, one quotient bit a cycle
    logic [DIV_W:0] w_shift, w_trial;
    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_trial = w_shift - {1'b0, r_in.duration_ticks, 1'b0};

    assign o_status.is_timed = (r_in.action == ACT_TIMED);
    assign o_status.div_last = (r_cnt == DIV_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.prep) begin
            r_mag     <= w_err_abs[31:0];
            r_err_pos <= !w_err[33] && (w_err != 34'sd0);
            r_off     <= w_off;
            r_num     <= w_num_full[NUM_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * r_kp;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (!w_trial[DIV_W]) begin
                r_rem <= w_trial[DIV_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.apply) begin
            r_out <= n_out;
        end
    end

    // Goto tick: clamp, minimum, slew
    logic [39:0]               w_p_full;
    logic [SPEED_W-1:0]        w_p, w_pm;
    logic signed [25:0]        w_sp, w_delta, w_gsn, w_st, w_slew;
    logic signed [SPEED_W-1:0] w_timed_sp;
    logic signed [30:0]        w_tgt;
    logic [15:0]               w_settle_inc;

    assign w_p_full = r_prod[47:8];
    assign w_p  = (w_p_full > {16'b0, r_limit}) ? r_limit : w_p_full[SPEED_W-1:0];
    assign w_pm = ((w_p != '0) && (w_p < {1'b0, r_min})) ? {1'b0, r_min} : w_p;
    assign w_sp = r_err_pos ? -$signed({2'b0, w_pm}) : $signed({2'b0, w_pm});
    assign w_gsn   = {{2{r_gsn[SPEED_W-1]}}, r_gsn};
    assign w_st    = {3'b0, r_step};
    assign w_delta = w_sp - w_gsn;

    always_comb begin
        if (w_delta > w_st) begin
            w_slew = w_gsn + w_st;
        end else if (w_delta < -w_st) begin
            w_slew = w_gsn - w_st;
        end else begin
            w_slew = w_sp;
        end
    end

    assign w_settle_inc = (r_settle == 16'hFFFF) ? r_settle : r_settle + 16'd1;
    assign w_timed_sp = (r_in.duration_ticks == '0) ? '0 :
                        r_off[14] ? -$signed({2'b0, r_num}) : $signed({2'b0, r_num});
    assign w_tgt = {r_turn[TURN_W-1], r_turn, r_prev} + {{16{r_off[14]}}, r_off};

    // Commit: next state and result
    always_comb begin
        n_mode    = r_mode;
        n_turn    = r_turn;
        n_prev    = r_prev;
        n_track   = r_track;
        n_target  = r_target;
        n_limit   = r_limit;
        n_gsn     = r_gsn;
        n_settle  = r_settle;
        n_left    = r_left;
        n_spd_tgt = r_spd_tgt;
        n_out     = '0;
        case (r_in.action)
            ACT_SAMPLE: begin
                if (r_track) begin
                    if ($signed({1'b0, r_in.angle}) - $signed({1'b0, r_prev})
                            > 15'sd8192) begin
                        n_turn = r_turn - 16'd1;
                    end else if ($signed({1'b0, r_in.angle}) - $signed({1'b0, r_prev})
                            < -15'sd8192) begin
                        n_turn = r_turn + 16'd1;
                    end
                end
                n_track = 1'b1;
                n_prev  = r_in.angle;
            end
            ACT_TICK: begin
                case (r_mode)
                    MODE_GOTO: begin
                        n_out.drive_update = 1'b1;
                        if (r_settle != 16'd0) begin
                            n_gsn     = '0;
                            n_spd_tgt = '0;
                            n_settle  = (r_mag < {18'b0, r_back_band}) ? w_settle_inc : 16'd0;
                        end else if (r_mag < {18'b0, r_stop_band}) begin
                            n_gsn     = '0;
                            n_spd_tgt = '0;
                            n_settle  = 16'd1;
                        end else begin
                            n_gsn     = w_slew[SPEED_W-1:0];
                            n_spd_tgt = w_slew[SPEED_W-1:0];
                            n_out.drive_speed = w_slew[SPEED_W-1:0];
                        end
                        if (n_settle >= r_settle_ticks) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_SPEED: begin
                        n_out.drive_update = 1'b1;
                        n_out.drive_speed  = r_spd_tgt;
                    end
                    MODE_TIMED: begin
                        if (r_left != '0) begin
                            n_left = r_left - DUR_W'(1);
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
            ACT_SPEED: begin
                n_mode    = MODE_SPEED;
                n_spd_tgt = r_in.speed_value;
            end
            ACT_STOP: begin
                n_mode    = MODE_IDLE;
                n_spd_tgt = '0;
                n_left    = '0;
                n_out.drive_update = 1'b1;
            end
            ACT_GOTO, ACT_NEAR: begin
                if (r_in.action == ACT_GOTO) begin
                    n_target = {{2{r_in.turn_number[TURN_W-1]}}, r_in.turn_number, r_in.angle};
                end else begin
                    n_target = {w_tgt[30], w_tgt[30:ANGLE_W], r_in.angle};
                end
                n_limit  = (r_in.speed_value > 0) ? r_in.speed_value : {1'b0, r_defmax};
                n_settle = 16'd0;
                n_gsn    = '0;
                n_mode   = MODE_GOTO;
            end
            ACT_TIMED: begin
                n_mode    = MODE_TIMED;
                n_spd_tgt = w_timed_sp;
                n_left    = r_in.duration_ticks;
                n_out.drive_update = 1'b1;
                n_out.drive_speed  = w_timed_sp;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        n_out.mode_now  = n_mode;
        n_out.goto_done = (n_settle >= r_settle_ticks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_turn    <= '0;
            r_prev    <= '0;
            r_track   <= 1'b0;
            r_target  <= '0;
            r_limit   <= '0;
            r_gsn     <= '0;
            r_settle  <= '0;
            r_left    <= '0;
            r_spd_tgt <= '0;
        end else if (i_cmd.apply) begin
            r_mode    <= n_mode;
            r_turn    <= n_turn;
            r_prev    <= n_prev;
            r_track   <= n_track;
            r_target  <= n_target;
            r_limit   <= n_limit;
            r_gsn     <= n_gsn;
            r_settle  <= n_settle;
            r_left    <= n_left;
            r_spd_tgt <= n_spd_tgt;
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp           <= 16'd256;
            r_stop_band    <= 14'd45;
            r_back_band    <= 14'd91;
            r_min          <= CFG_W'(256);
            r_step         <= CFG_W'(256);
            r_settle_ticks <= 16'd20;
            r_defmax       <= CFG_W'(11520);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:     r_kp           <= i_cfg_data[15:0];
                CFG_STOP:   r_stop_band    <= i_cfg_data[13:0];
                CFG_BACK:   r_back_band    <= i_cfg_data[13:0];
                CFG_MIN:    r_min          <= i_cfg_data;
                CFG_STEP:   r_step         <= i_cfg_data;
                CFG_SETTLE: r_settle_ticks <= i_cfg_data[15:0];
                CFG_DEFMAX: r_defmax       <= i_cfg_data;
                default:    r_kp           <= r_kp;
            endcase
        end
    end

    assign o_out = r_out;

endmodule
